FILE: design/repeating_timed_event_queue_macros.svh
// assertion helpers shared by the queue modules
`ifndef REPEATING_TIMED_EVENT_QUEUE_MACROS_SVH
`define REPEATING_TIMED_EVENT_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define RTEQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rteq implication check failed");

// next-cycle implication, checked out of reset
`define RTEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rteq next-cycle check failed");

`endif

FILE: design/rteq_pkg.sv
package rteq_pkg;

  localparam int TABLE_DEPTH        = 16;
  localparam int MAX_FIRES_PER_TICK = 64;
  localparam int IDX_W              = $clog2(TABLE_DEPTH);
  localparam int FIRE_W             = $clog2(MAX_FIRES_PER_TICK + 1);
  localparam int SLOT_W             = 4;
  localparam int TIME_W             = 48;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_PROCESS = 2'd1;
  localparam logic [1:0] OP_SHIFT   = 2'd2;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_FIRED    = 3'd3;
  localparam logic [2:0] ST_NONE_DUE = 3'd4;
  localparam logic [2:0] ST_SHIFTED  = 3'd5;
  localparam logic [2:0] ST_BAD      = 3'd6;

  typedef struct packed {
    logic capture;
    logic exec;
    logic proc_init;
    logic scan_step;
    logic decide;
    logic use_handle;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       scan_last;
    logic       fire_ok;
    logic       pend_valid;
    logic       out_valid;
  } sts_t;

  function automatic logic [TIME_W-1:0] sat_add48(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

FILE: design/rteq_ctrl.sv
module rteq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_ready,
  input  rteq_pkg::sts_t  sts,
  output rteq_pkg::cmd_t  cmd
);
`include "repeating_timed_event_queue_macros.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WOUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE) && !sts.out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.capture    = in_valid && in_ready;
    cmd.use_handle = (state == S_EXEC);
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          priority if (sts.op == rteq_pkg::OP_ADD || sts.op == rteq_pkg::OP_SHIFT) begin
            state_next = S_EXEC;
          end else if (sts.op == rteq_pkg::OP_PROCESS) begin
            cmd.proc_init = 1'b1;
            state_next    = S_SCAN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        priority if (sts.fire_ok && sts.pend_valid) begin
          state_next = S_WOUT;
        end else if (sts.fire_ok) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WOUT: begin
        if (out_ready) begin
          state_next = S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `RTEQ_ASSERT_IMPL(a_wout_has_result, clk, rst, state == S_WOUT, sts.out_valid)
  `RTEQ_ASSERT_NEXT(a_no_fire_ends, clk, rst, (state == S_DECIDE) && !sts.fire_ok,
                    state == S_IDLE)
  `RTEQ_ASSERT_NEXT(a_exec_one_cycle, clk, rst, state == S_EXEC, state == S_IDLE)

endmodule

FILE: design/rteq_datapath.sv
module rteq_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  rteq_pkg::cmd_t               cmd,
  output rteq_pkg::sts_t               sts,
  input  logic [1:0]                   opcode,
  input  logic [rteq_pkg::TIME_W-1:0]  now_ms,
  input  logic [31:0]                  wait_ms,
  input  logic [31:0]                  event_kind,
  input  logic [31:0]                  payload,
  input  logic [31:0]                  repeat_interval,
  input  logic [7:0]                   repeat_count,
  input  logic [15:0]                  owner_id,
  input  logic                         owner_eligible,
  input  logic [rteq_pkg::SLOT_W-1:0]  slot_handle,
  input  logic signed [31:0]           delta_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   status,
  output logic [rteq_pkg::SLOT_W-1:0]  slot,
  output logic [31:0]                  kind_out,
  output logic [15:0]                  owner_out,
  output logic [31:0]                  payload_out,
  output logic [rteq_pkg::TIME_W-1:0]  due_out,
  output logic                         last
);
`include "repeating_timed_event_queue_macros.svh"

  localparam int D  = rteq_pkg::TABLE_DEPTH;
  localparam int IW = rteq_pkg::IDX_W;
  localparam int TW = rteq_pkg::TIME_W;
  localparam int FW = rteq_pkg::FIRE_W;
  localparam int SLOT_W_L = rteq_pkg::SLOT_W;

  // event table
  logic          ent_valid   [D];
  logic [TW-1:0] due_time    [D];
  logic [31:0]   ent_kind    [D];
  logic [31:0]   ent_payload [D];
  logic [31:0]   ent_interval[D];
  logic [7:0]    ent_repeats [D];
  logic [15:0]   ent_owner   [D];
  logic [15:0]   insert_order[D];
  logic [15:0]   order_counter;

  // captured item
  logic [1:0]        op_r;
  logic [TW-1:0]     now_r;
  logic [31:0]       wait_r, kind_r, payload_r, interval_r;
  logic [7:0]        count_r;
  logic [15:0]       owner_r;
  logic              elig_r;
  logic [SLOT_W_L-1:0] handle_r;
  logic signed [31:0] delta_r;

  // scan and best candidate
  logic [IW-1:0] scan_idx;
  logic          best_found;
  logic [IW-1:0] best_idx;
  logic [TW-1:0] best_due;
  logic [15:0]   best_age;
  logic [31:0]   best_kind, best_payload, best_interval;
  logic [7:0]    best_repeats;
  logic [15:0]   best_owner;
  logic [FW-1:0] fire_cnt;

  // fired result held back until we know whether it is the last one
  logic          pend_valid;
  logic [IW-1:0] pend_idx;
  logic [TW-1:0] pend_due;
  logic [31:0]   pend_kind, pend_payload;
  logic [15:0]   pend_owner;

  logic [IW-1:0] rd_idx;
  logic [TW-1:0] rd_due;
  logic [15:0]   rd_age;
  logic          better;
  logic          fire_ok;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          bad_handle;
  logic [32:0]   neg_mag;
  logic [TW-1:0] mag48;
  logic [TW-1:0] shifted_due;
  logic [TW-1:0] add_due;
  logic [TW-1:0] resched_due;

  assign rd_idx = cmd.use_handle ? handle_r[IW-1:0] : scan_idx;
  assign rd_due = due_time[rd_idx];
  assign rd_age = order_counter - insert_order[rd_idx];
  assign better = ent_valid[rd_idx] &&
                  (!best_found || (rd_due < best_due) ||
                   ((rd_due == best_due) && (rd_age > best_age)));

  assign fire_ok = best_found && (best_due <= now_r) &&
                   (fire_cnt < FW'(rteq_pkg::MAX_FIRES_PER_TICK));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (!ent_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign bad_handle  = ({1'b0, handle_r} >= (SLOT_W_L + 1)'(D)) || !ent_valid[rd_idx];
  assign neg_mag     = 33'd0 - {delta_r[31], delta_r};
  assign mag48       = {{(TW - 33){1'b0}}, neg_mag};
  assign shifted_due = delta_r[31] ? ((rd_due < mag48) ? '0 : rd_due - mag48)
                                   : rteq_pkg::sat_add48(rd_due, {16'd0, delta_r});
  assign add_due     = rteq_pkg::sat_add48(now_r, {16'd0, wait_r});
  assign resched_due = rteq_pkg::sat_add48(best_due, {16'd0, best_interval});

  assign sts.op         = opcode;
  assign sts.scan_last  = (scan_idx == IW'(D - 1));
  assign sts.fire_ok    = fire_ok;
  assign sts.pend_valid = pend_valid;
  assign sts.out_valid  = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= opcode;
      now_r      <= now_ms;
      wait_r     <= wait_ms;
      kind_r     <= event_kind;
      payload_r  <= payload;
      interval_r <= repeat_interval;
      count_r    <= repeat_count;
      owner_r    <= owner_id;
      elig_r     <= owner_eligible;
      handle_r   <= slot_handle;
      delta_r    <= delta_ms;
    end
  end

  // table contents, no reset
  always_ff @(posedge clk) begin
    if (cmd.exec && op_r == rteq_pkg::OP_ADD && elig_r && free_found) begin
      due_time[free_idx]     <= add_due;
      ent_kind[free_idx]     <= kind_r;
      ent_payload[free_idx]  <= payload_r;
      ent_interval[free_idx] <= interval_r;
      ent_repeats[free_idx]  <= count_r;
      ent_owner[free_idx]    <= owner_r;
      insert_order[free_idx] <= order_counter;
    end else if (cmd.exec && op_r == rteq_pkg::OP_SHIFT && !bad_handle) begin
      due_time[rd_idx]     <= shifted_due;
      insert_order[rd_idx] <= order_counter;
    end else if (cmd.decide && fire_ok && best_repeats != 8'd0) begin
      due_time[best_idx]     <= resched_due;
      ent_repeats[best_idx]  <= best_repeats - 8'd1;
      insert_order[best_idx] <= order_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) begin
        ent_valid[i] <= 1'b0;
      end
      order_counter <= '0;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      best_found    <= 1'b0;
      scan_idx      <= '0;
      fire_cnt      <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.exec) begin
        out_valid <= 1'b1;
        last      <= 1'b1;
        kind_out    <= '0;
        owner_out   <= '0;
        payload_out <= '0;
        slot        <= '0;
        due_out     <= '0;
        if (op_r == rteq_pkg::OP_ADD) begin
          priority if (!elig_r) begin
            status <= rteq_pkg::ST_REJECTED;
          end else if (!free_found) begin
            status <= rteq_pkg::ST_FULL;
          end else begin
            status              <= rteq_pkg::ST_ADDED;
            slot                <= SLOT_W_L'(free_idx);
            due_out             <= add_due;
            ent_valid[free_idx] <= 1'b1;
            order_counter       <= order_counter + 16'd1;
          end
        end else begin
          slot <= handle_r;
          if (bad_handle) begin
            status <= rteq_pkg::ST_BAD;
          end else begin
            status        <= rteq_pkg::ST_SHIFTED;
            due_out       <= shifted_due;
            order_counter <= order_counter + 16'd1;
          end
        end
      end
      if (cmd.proc_init) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
        pend_valid <= 1'b0;
        fire_cnt   <= '0;
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + IW'(1);
        if (better) begin
          best_found    <= 1'b1;
          best_idx      <= rd_idx;
          best_due      <= rd_due;
          best_age      <= rd_age;
          best_kind     <= ent_kind[rd_idx];
          best_payload  <= ent_payload[rd_idx];
          best_interval <= ent_interval[rd_idx];
          best_repeats  <= ent_repeats[rd_idx];
          best_owner    <= ent_owner[rd_idx];
        end
      end
      if (cmd.decide) begin
        if (pend_valid || !fire_ok) begin
          out_valid   <= 1'b1;
          last        <= !fire_ok;
          status      <= pend_valid ? rteq_pkg::ST_FIRED : rteq_pkg::ST_NONE_DUE;
          slot        <= pend_valid ? SLOT_W_L'(pend_idx) : '0;
          kind_out    <= pend_valid ? pend_kind : '0;
          owner_out   <= pend_valid ? pend_owner : '0;
          payload_out <= pend_valid ? pend_payload : '0;
          due_out     <= pend_valid ? pend_due : '0;
        end
        if (fire_ok) begin
          pend_valid   <= 1'b1;
          pend_idx     <= best_idx;
          pend_due     <= best_due;
          pend_kind    <= best_kind;
          pend_payload <= best_payload;
          pend_owner   <= best_owner;
          fire_cnt     <= fire_cnt + FW'(1);
          scan_idx     <= '0;
          best_found   <= 1'b0;
          if (best_repeats != 8'd0) begin
            order_counter <= order_counter + 16'd1;
          end else begin
            ent_valid[best_idx] <= 1'b0;
          end
        end
      end
    end
  end

  `RTEQ_ASSERT_IMPL(a_fired_is_due, clk, rst,
                    out_valid && (status == rteq_pkg::ST_FIRED), due_out <= now_r)
  `RTEQ_ASSERT_IMPL(a_fire_limit, clk, rst, 1'b1,
                    fire_cnt <= FW'(rteq_pkg::MAX_FIRES_PER_TICK))
  `RTEQ_ASSERT_NEXT(a_fire_sets_pending, clk, rst, cmd.decide && fire_ok, pend_valid)

endmodule

FILE: design/repeating_timed_event_queue.sv
// Timed event queue with a 16-slot table. One transaction in carries an add, process or shift
// command; add and shift return one result each, unknown opcodes none.
// A process command walks the whole table once per fired event and once more at the end (a scan
// of every slot plus a decision step each time, at most 64 fires), and it waits on any output stall;
// each fired result is released one scan late, once it is known whether another event follows,
// which is what sets the last flag. Only one command is in flight at a time.
module repeating_timed_event_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic [rteq_pkg::TIME_W-1:0]  now_ms,
  input  logic [31:0]                  wait_ms,
  input  logic [31:0]                  event_kind,
  input  logic [31:0]                  payload,
  input  logic [31:0]                  repeat_interval,
  input  logic [7:0]                   repeat_count,
  input  logic [15:0]                  owner_id,
  input  logic                         owner_eligible,
  input  logic [rteq_pkg::SLOT_W-1:0]  slot_handle,
  input  logic signed [31:0]           delta_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   status,
  output logic [rteq_pkg::SLOT_W-1:0]  slot,
  output logic [31:0]                  kind_out,
  output logic [15:0]                  owner_out,
  output logic [31:0]                  payload_out,
  output logic [rteq_pkg::TIME_W-1:0]  due_out,
  output logic                         last
);

  // command and status between sequencer and table datapath
  rteq_pkg::cmd_t cmd;
  rteq_pkg::sts_t sts;

  // sequencer: idle, an exec step for add/shift, scan and decide loop for process
  rteq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // event table, earliest-entry scan, pending fired result and output register
  rteq_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .opcode          (opcode),
    .now_ms          (now_ms),
    .wait_ms         (wait_ms),
    .event_kind      (event_kind),
    .payload         (payload),
    .repeat_interval (repeat_interval),
    .repeat_count    (repeat_count),
    .owner_id        (owner_id),
    .owner_eligible  (owner_eligible),
    .slot_handle     (slot_handle),
    .delta_ms        (delta_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .slot            (slot),
    .kind_out        (kind_out),
    .owner_out       (owner_out),
    .payload_out     (payload_out),
    .due_out         (due_out),
    .last            (last)
  );

endmodule

FILE: verif/repeating_timed_event_queue_tb.sv
module repeating_timed_event_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIME_W             = rteq_pkg::TIME_W;
  localparam int SLOT_W             = rteq_pkg::SLOT_W;
  localparam int TABLE_DEPTH        = rteq_pkg::TABLE_DEPTH;
  localparam int MAX_FIRES_PER_TICK = rteq_pkg::MAX_FIRES_PER_TICK;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  // a process tick rescans the table for every fire and also waits on output stalls
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = rteq_pkg::OP_ADD;
  logic [TIME_W-1:0] now_ms = '0;
  logic [31:0] wait_ms = '0;
  logic [31:0] event_kind = '0;
  logic [31:0] payload = '0;
  logic [31:0] repeat_interval = '0;
  logic [7:0] repeat_count = '0;
  logic [15:0] owner_id = '0;
  logic owner_eligible = 1'b0;
  logic [SLOT_W-1:0] slot_handle = '0;
  logic signed [31:0] delta_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [SLOT_W-1:0] slot;
  logic [31:0] kind_out;
  logic [15:0] owner_out;
  logic [31:0] payload_out;
  logic [TIME_W-1:0] due_out;
  logic last;

  repeating_timed_event_queue u_dut (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one expected outcome of a transaction
  typedef struct {
    logic [2:0] status;
    logic [SLOT_W-1:0] slot;
    logic [31:0] kind;
    logic [15:0] owner;
    logic [31:0] pay;
    logic [TIME_W-1:0] due;
    logic last;
  } outcome_t;

  outcome_t pending_outcomes[$];
  int errors = 0;
  int cycle_count = 0;
  bit idle_enable = 1'b1;     // random gaps on both sides
  bit sink_hold = 1'b0;       // long receiver back-pressure
  logic [TIME_W-1:0] clock_ms = '0;  // the simulated "now" that tests advance
  realtime acc_stamp = -1.0;  // time of the last input acceptance

  // shadow copy of the event table
  bit sh_valid[TABLE_DEPTH];
  logic [TIME_W-1:0] sh_due[TABLE_DEPTH];
  logic [31:0] sh_kind[TABLE_DEPTH];
  logic [31:0] sh_pay[TABLE_DEPTH];
  logic [31:0] sh_ivl[TABLE_DEPTH];
  logic [7:0] sh_rep[TABLE_DEPTH];
  logic [15:0] sh_owner[TABLE_DEPTH];
  logic [15:0] sh_stamp[TABLE_DEPTH];
  logic [15:0] sh_seq = '0;

  function automatic logic [TIME_W-1:0] time_sat_add(logic [TIME_W-1:0] a,
                                                     logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic void restamp(int i);
    sh_stamp[i] = sh_seq;
    sh_seq = sh_seq + 16'd1;
  endfunction

  function automatic void push_outcome(logic [2:0] st, logic [SLOT_W-1:0] sl,
                                       logic [31:0] k, logic [15:0] o,
                                       logic [31:0] p, logic [TIME_W-1:0] d);
    outcome_t r;
    r.status = st; r.slot = sl; r.kind = k; r.owner = o; r.pay = p; r.due = d;
    r.last = 1'b0;
    pending_outcomes.push_back(r);
  endfunction

  // earliest due slot, ties to the oldest stamp then lowest slot; -1 if empty
  function automatic int earliest_slot();
    int b;
    logic [15:0] ai, ab;
    b = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!sh_valid[i]) continue;
      if (b < 0 || sh_due[i] < sh_due[b]) begin
        b = i;
      end else if (sh_due[i] == sh_due[b]) begin
        ai = sh_seq - sh_stamp[i];
        ab = sh_seq - sh_stamp[b];
        if (ai > ab) b = i;
      end
    end
    return b;
  endfunction

  // predict the results of one transaction and queue them
  function automatic void predict_queue(logic [1:0] op, logic [TIME_W-1:0] now,
                                        logic [31:0] wt, logic [31:0] k,
                                        logic [31:0] p, logic [31:0] ivl,
                                        logic [7:0] rc, logic [15:0] own,
                                        logic elig, logic [SLOT_W-1:0] h,
                                        logic signed [31:0] d);
    int n, b, fs;
    logic [TIME_W-1:0] mag;
    n = 0;
    unique case (op)
      rteq_pkg::OP_ADD: begin
        fs = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (!sh_valid[i] && fs < 0) fs = i;
        if (!elig) push_outcome(rteq_pkg::ST_REJECTED, '0, '0, '0, '0, '0);
        else if (fs < 0) push_outcome(rteq_pkg::ST_FULL, '0, '0, '0, '0, '0);
        else begin
          sh_valid[fs] = 1'b1;
          sh_due[fs] = time_sat_add(now, {16'd0, wt});
          sh_kind[fs] = k; sh_pay[fs] = p; sh_ivl[fs] = ivl;
          sh_rep[fs] = rc; sh_owner[fs] = own;
          restamp(fs);
          push_outcome(rteq_pkg::ST_ADDED, fs[SLOT_W-1:0], '0, '0, '0, sh_due[fs]);
        end
        n = 1;
      end
      rteq_pkg::OP_PROCESS: begin
        while (n < MAX_FIRES_PER_TICK) begin
          b = earliest_slot();
          if (b < 0 || sh_due[b] > now) break;
          push_outcome(rteq_pkg::ST_FIRED, b[SLOT_W-1:0], sh_kind[b], sh_owner[b],
                       sh_pay[b], sh_due[b]);
          n++;
          if (sh_rep[b] != 0) begin
            sh_due[b] = time_sat_add(sh_due[b], {16'd0, sh_ivl[b]});
            sh_rep[b] = sh_rep[b] - 8'd1;
            restamp(b);
          end else begin
            sh_valid[b] = 1'b0;
          end
        end
        if (n == 0) begin
          push_outcome(rteq_pkg::ST_NONE_DUE, '0, '0, '0, '0, '0);
          n = 1;
        end
      end
      rteq_pkg::OP_SHIFT: begin
        if (!sh_valid[h]) push_outcome(rteq_pkg::ST_BAD, h, '0, '0, '0, '0);
        else begin
          if (d < 0) begin
            mag = {16'd0, -d};
            if (d == 32'sh80000000) mag = 48'h80000000;
            sh_due[h] = (sh_due[h] < mag) ? '0 : sh_due[h] - mag;
          end else begin
            sh_due[h] = time_sat_add(sh_due[h], {16'd0, d});
          end
          restamp(h);
          push_outcome(rteq_pkg::ST_SHIFTED, h, '0, '0, '0, sh_due[h]);
        end
        n = 1;
      end
      default: ;  // unknown opcode: no results
    endcase
    if (n > 0) pending_outcomes[$].last = 1'b1;
  endfunction

  // send one transaction, prediction made at acceptance
  task automatic send_item(logic [1:0] op, logic [TIME_W-1:0] now, logic [31:0] wt,
                           logic [31:0] k, logic [31:0] p, logic [31:0] ivl,
                           logic [7:0] rc, logic [15:0] own, logic elig,
                           logic [SLOT_W-1:0] h, logic signed [31:0] d);
    while (idle_enable && $urandom_range(99) < 17) @(posedge clk);
    // valid was just dropped at this edge, so wait for another edge before offering the next one
    if ($realtime == acc_stamp) @(posedge clk);
    in_valid <= 1'b1;
    opcode <= op; now_ms <= now; wait_ms <= wt; event_kind <= k; payload <= p;
    repeat_interval <= ivl; repeat_count <= rc; owner_id <= own;
    owner_eligible <= elig; slot_handle <= h; delta_ms <= d;
    // ready is stable mid-cycle, so seeing it at the falling edge means acceptance next
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_queue(op, now, wt, k, p, ivl, rc, own, elig, h, d);
    in_valid <= 1'b0;
    acc_stamp = $realtime;
  endtask

  task automatic send_add(logic [31:0] wt, logic [31:0] ivl, logic [7:0] rc);
    send_item(rteq_pkg::OP_ADD, clock_ms, wt, $urandom, $urandom, ivl, rc,
              16'($urandom), 1'b1, '0, '0);
  endtask

  task automatic send_process();
    send_item(rteq_pkg::OP_PROCESS, clock_ms, $urandom, $urandom, $urandom, $urandom,
              8'($urandom), 16'($urandom), 1'($urandom), 4'($urandom),
              $signed($urandom));
  endtask

  task automatic send_shift(logic [SLOT_W-1:0] h, logic signed [31:0] d);
    send_item(rteq_pkg::OP_SHIFT, clock_ms, $urandom, $urandom, $urandom, $urandom,
              8'($urandom), 16'($urandom), 1'($urandom), h, d);
  endtask

  task automatic wait_drained();
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // receiver ready: random stalls, or a long hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !sink_hold && !(idle_enable && $urandom_range(99) < 17);
  end

  // result checker
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result transaction: status %0d slot %0d", status, slot);
        errors++;
      end else begin
        e = pending_outcomes.pop_front();
        if (status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, status); errors++;
        end
        if (slot !== e.slot) begin
          $error("slot: expected %0d actual %0d", e.slot, slot); errors++;
        end
        if (kind_out !== e.kind) begin
          $error("kind_out: expected %h actual %h", e.kind, kind_out); errors++;
        end
        if (owner_out !== e.owner) begin
          $error("owner_out: expected %h actual %h", e.owner, owner_out); errors++;
        end
        if (payload_out !== e.pay) begin
          $error("payload_out: expected %h actual %h", e.pay, payload_out); errors++;
        end
        if (due_out !== e.due) begin
          $error("due_out: expected %h actual %h", e.due, due_out); errors++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, last); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("repeating_timed_event_queue_tb: FAIL");
      $finish;
    end
  end

  // adds, rejection, full table, shifts incl. saturation and bad handles, an unknown opcode, process ticks
  task automatic test_directed();
    clock_ms = 48'd1000;
    send_item(rteq_pkg::OP_ADD, clock_ms, 32'd5, '1, '1, 32'd3, 8'd2, '1, 1'b0, '0, '0);
    send_item(rteq_pkg::OP_ADD, TIME_MAX, '1, '1, '1, '1, 8'hFF, '1, 1'b1, '0, '0);
    send_shift(4'd5, 32'sd1);                   // free slot
    for (int i = 1; i < TABLE_DEPTH; i++) send_add(32'(i % 3), 32'd2, 8'(i % 2));
    send_add(32'd1, '0, '0);                    // table full
    send_shift(4'd0, 32'sh7FFFFFFF);            // saturate high
    send_shift(4'd0, 32'sh80000000);
    send_shift(4'd1, 32'sh80000000);            // saturate at zero
    send_item(2'd3, clock_ms, '0, '0, '0, '0, '0, '0, 1'b1, '0, '0);
    clock_ms = clock_ms + 48'd10;
    send_process();                             // ties and repeats within a tick
    clock_ms = TIME_MAX;
    send_process();
    send_process();                             // slot 0 repeats and is still due
  endtask

  // many repeating events due at once hit the fire limit
  task automatic test_fire_limit();
    clock_ms = 48'd50000;
    for (int i = 0; i < 8; i++) send_add(32'd0, 32'd0, 8'd20);
    clock_ms = clock_ms + 48'd1;
    send_process();
    send_process();
    send_process();
  endtask

  // receiver holds off while the sender keeps offering adds
  task automatic test_backpressure();
    sink_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_add($urandom_range(20), 32'd5, 8'($urandom_range(3)));
    join
    clock_ms = clock_ms + 48'd30;
    send_process();
    wait_drained();
  endtask

  // random mix of adds, process ticks, shifts and unknown opcodes, mostly near the current time
  task automatic test_random(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) idle_enable = 1'b0;   // stretch without gaps
      if (i == count / 2 + 40) idle_enable = 1'b1;
      sel = $urandom_range(99);
      if (sel < 40) begin
        send_item(rteq_pkg::OP_ADD, clock_ms,
                  ($urandom_range(9) == 0) ? $urandom : $urandom_range(40),
                  $urandom, $urandom, ($urandom_range(9) == 0) ? $urandom : $urandom_range(15),
                  8'(($urandom_range(5) == 0) ? $urandom : $urandom_range(3)),
                  16'($urandom), $urandom_range(9) != 0, '0, '0);
      end else if (sel < 75) begin
        clock_ms = ($urandom_range(49) == 0) ? TIME_W'({$urandom, $urandom}) :
                   clock_ms + TIME_W'($urandom_range(30));
        send_process();
      end else if (sel < 95) begin
        send_shift(4'($urandom), ($urandom_range(4) == 0) ? $signed($urandom) :
                   $signed($urandom_range(40)) - 32'sd20);
      end else begin
        send_item(2'd3, TIME_W'({$urandom, $urandom}), $urandom, $urandom, $urandom,
                  $urandom, 8'($urandom), 16'($urandom), 1'($urandom), 4'($urandom),
                  $signed($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) sh_valid[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fire_limit();
    test_backpressure();
    test_random(220);
    wait_drained();
    repeat (1200) @(posedge clk);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("repeating_timed_event_queue_tb: PASS");
    end else begin
      $display("repeating_timed_event_queue_tb: FAIL");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+design
design/rteq_pkg.sv
design/rteq_ctrl.sv
design/rteq_datapath.sv
design/repeating_timed_event_queue.sv
verif/repeating_timed_event_queue_tb.sv
